// File: hw/rtl/ucp_pkg.sv
// shared constants for the cross product unit normal block
// no dependencies
package ucp_pkg;

    // default component width of the input vectors
    localparam int COMPONENT_BITS_DEF = 12;
    // default fraction bits of the normal components
    localparam int FRACTION_BITS_DEF  = 14;
    // width of each normal component on the output
    localparam int OUT_BITS           = 16;

    // flags that travel alongside the arithmetic
    typedef struct packed {
        logic       is_null;
        logic [2:0] neg;
    } t_side;

endpackage

// File: hw/rtl/ucp_if.sv
// valid/ready channel interfaces for the cross product unit normal block
// depends on ucp_pkg
interface ucp_in_if #(
    parameter int COMPONENT_BITS = ucp_pkg::COMPONENT_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] first_x;
    logic signed [COMPONENT_BITS-1:0] first_y;
    logic signed [COMPONENT_BITS-1:0] first_z;
    logic signed [COMPONENT_BITS-1:0] second_x;
    logic signed [COMPONENT_BITS-1:0] second_y;
    logic signed [COMPONENT_BITS-1:0] second_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
        output ready
    );
endinterface

interface ucp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ucp_pkg::OUT_BITS-1:0] normal_x;
    logic signed [ucp_pkg::OUT_BITS-1:0] normal_y;
    logic signed [ucp_pkg::OUT_BITS-1:0] normal_z;
    logic                               is_null;

    modport source (
        output valid, normal_x, normal_y, normal_z, is_null,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, is_null,
        output ready
    );
endinterface

// File: hw/rtl/unit_normal_of_cross_product.sv
// Unit normal of the cross product of two 3-D integer vectors, signed Q1.FRACTION_BITS.
// One beat is accepted every cycle while the output is taken; each beat passes through the
// partial product, cross product, square and sum stages, the square root pipeline (one
// root bit per stage), the three divider pipelines (one quotient bit per stage) and the
// output stage. A zero cross product gives a zero normal with is_null set.
// A stalled output holds the whole pipeline.
// depends on ucp_pkg, ucp_if, ucp_sqrt, ucp_div
module unit_normal_of_cross_product #(
    parameter int COMPONENT_BITS = ucp_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = ucp_pkg::FRACTION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ucp_in_if.sink     i_in,
    ucp_out_if.source  o_out
);
    import ucp_pkg::*;

    localparam int CB  = COMPONENT_BITS;
    localparam int MW  = 2 * CB;
    localparam int CW  = MW + 1;
    localparam int SW  = 2 * MW + 2;
    localparam int RW  = SW / 2;
    localparam int QW  = FRACTION_BITS + 1;
    localparam int DL  = RW + QW + 1;
    localparam int LAT = 4 + DL + 1;

    logic                  s_en;
    logic [LAT-1:0]        r_vld;

    logic signed [MW-1:0]  r_p   [6];
    logic [MW-1:0]         r_mag2 [3];
    t_side                 r_side2;
    logic [MW-1:0]         r_mag3 [3];
    logic [2*MW-1:0]       r_sq   [3];
    t_side                 r_side3;
    logic [SW-1:0]         r_sum;
    logic [MW-1:0]         r_mag4 [3];
    t_side                 r_side4;
    logic [MW-1:0]         r_magd [RW][3];
    t_side                 r_sided [DL];
    logic [RW-1:0]         s_root;
    logic [QW-1:0]         s_quo [3];
    logic [OUT_BITS-1:0]   r_out [3];
    logic                  r_null;

    logic signed [CW-1:0]  s_c [3];
    logic [MW-1:0]         s_m [3];

    // whole pipeline advances unless the output beat is held
    assign s_en       = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = s_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // stage 1: the six partial products
    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_p[0] <= i_in.first_y * i_in.second_z;
            r_p[1] <= i_in.first_z * i_in.second_y;
            r_p[2] <= i_in.first_z * i_in.second_x;
            r_p[3] <= i_in.first_x * i_in.second_z;
            r_p[4] <= i_in.first_x * i_in.second_y;
            r_p[5] <= i_in.first_y * i_in.second_x;
        end
    end

    // stage 2: cross product, magnitudes and signs
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_c[i] = CW'(r_p[2*i]) - CW'(r_p[2*i+1]);
            s_m[i] = s_c[i][CW-1] ? MW'(-s_c[i]) : MW'(s_c[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag2[i]      <= s_m[i];
                r_side2.neg[i] <= s_c[i][CW-1];
            end
            r_side2.is_null <= (s_c[0] == '0) && (s_c[1] == '0) && (s_c[2] == '0);
        end
    end

    // stage 3: squares
    always_ff @(posedge i_clk) begin
        if (s_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i]   <= r_mag2[i] * r_mag2[i];
                r_mag3[i] <= r_mag2[i];
            end
            r_side3 <= r_side2;
        end
    end

    // stage 4: sum of squares
    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_sum   <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_mag4  <= r_mag3;
            r_side4 <= r_side3;
        end
    end

    ucp_sqrt #(
        .SW (SW),
        .RW (RW)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (s_en),
        .i_rad  (r_sum),
        .o_root (s_root)
    );

    // magnitudes wait for the root, flags wait for the quotients
    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_magd[0]  <= r_mag4;
            r_sided[0] <= r_side4;
            for (int k = 1; k < RW; k++) begin
                r_magd[k] <= r_magd[k-1];
            end
            for (int k = 1; k < DL; k++) begin
                r_sided[k] <= r_sided[k-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        ucp_div #(
            .MW (MW),
            .RW (RW),
            .FB (FRACTION_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (s_en),
            .i_mag (r_magd[RW-1][i]),
            .i_len (s_root),
            .o_quo (s_quo[i])
        );
    end

    // output stage: apply sign, zero on a null cross product
    always_ff @(posedge i_clk) begin
        if (s_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_sided[DL-1].is_null) begin
                    r_out[i] <= '0;
                end else if (r_sided[DL-1].neg[i]) begin
                    r_out[i] <= -OUT_BITS'(s_quo[i]);
                end else begin
                    r_out[i] <= OUT_BITS'(s_quo[i]);
                end
            end
            r_null <= r_sided[DL-1].is_null;
        end
    end

    assign o_out.valid    = r_vld[LAT-1];
    assign o_out.normal_x = r_out[0];
    assign o_out.normal_y = r_out[1];
    assign o_out.normal_z = r_out[2];
    assign o_out.is_null  = r_null;

endmodule

// File: hw/rtl/ucp_sqrt.sv
// pipelined floor square root, one result bit per stage
// no package dependencies
module ucp_sqrt #(
    parameter int SW = 50,
    parameter int RW = 25
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [SW-1:0] i_rad,
    output logic [RW-1:0] o_root
);

    logic [RW:0]   r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [SW-1:0] r_rad  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW:0]   s_rem;
        logic [RW-1:0] s_root;
        logic [SW-1:0] s_rad;
        logic [RW+2:0] s_try;
        logic [RW+2:0] s_sub;
        logic [RW:0]   n_rem;
        logic [RW-1:0] n_root;

        // previous stage or pipeline entry
        if (k == 0) begin : g_first
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rad  = i_rad;
        end else begin : g_next
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_rad  = r_rad[k-1];
        end

        // bring in two radicand bits and try the next root bit
        always_comb begin
            s_try = {s_rem, s_rad[SW-1:SW-2]};
            s_sub = {1'b0, s_root, 2'b01};
            if (s_try >= s_sub) begin
                n_rem  = (RW+1)'(s_try - s_sub);
                n_root = {s_root[RW-2:0], 1'b1};
            end else begin
                n_rem  = s_try[RW:0];
                n_root = {s_root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= {s_rad[SW-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

// File: hw/rtl/ucp_div.sv
// pipelined rounded division of a magnitude by the length, one quotient bit per stage
// no package dependencies
module ucp_div #(
    parameter int MW = 24,
    parameter int RW = 25,
    parameter int FB = 14
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [MW-1:0] i_mag,
    input  logic [RW-1:0] i_len,
    output logic [FB:0]   o_quo
);

    localparam int QW = FB + 1;
    localparam int NW = MW + FB + 1;

    logic [NW-1:0] s_num;
    logic [RW-1:0] r_rem0;
    logic [QW-1:0] r_lo0;
    logic [RW-1:0] r_len0;
    logic [RW-1:0] r_rem [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [RW-1:0] r_len [QW];

    // numerator with half the divisor added for round to nearest
    assign s_num = (NW'(i_mag) << FB) + NW'(i_len >> 1);

    // upper numerator bits already lie below the divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0 <= RW'(s_num[NW-1:QW]);
            r_lo0  <= s_num[QW-1:0];
            r_len0 <= i_len;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0] s_rem;
        logic [QW-1:0] s_lo;
        logic [RW-1:0] s_len;
        logic [RW:0]   s_try;
        logic [RW-1:0] n_rem;
        logic          n_bit;

        if (k == 0) begin : g_first
            assign s_rem = r_rem0;
            assign s_lo  = r_lo0;
            assign s_len = r_len0;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_lo  = r_lo[k-1];
            assign s_len = r_len[k-1];
        end

        // shift in one numerator bit, subtract when it fits
        always_comb begin
            s_try = {s_rem, s_lo[QW-1]};
            if (s_try >= {1'b0, s_len}) begin
                n_rem = RW'(s_try - {1'b0, s_len});
                n_bit = 1'b1;
            end else begin
                n_rem = s_try[RW-1:0];
                n_bit = 1'b0;
            end
        end

        // low register shifts numerator bits out and quotient bits in
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_lo[k]  <= {s_lo[QW-2:0], n_bit};
                r_len[k] <= s_len;
            end
        end
    end

    assign o_quo = r_lo[QW-1];

endmodule
